### sv/khpc_pkg.sv
`timescale 1ns / 1ps
// Package for the keypad HID power controller: sizes, register indexes,
// keymap table and the types shared by the compare unit, the scanner and the top level.
package khpc_pkg;

   localparam int NUM_KEYMAPS = 2;
   localparam int NUM_BUTTONS = 13;
   localparam int MAX_KEYS    = 6;
   localparam int ROM_SIZE    = 26;

   localparam int KMI_W     = (NUM_KEYMAPS > 1) ? $clog2(NUM_KEYMAPS) : 1;
   localparam int BTN_IDX_W = (NUM_BUTTONS > 1) ? $clog2(NUM_BUTTONS) : 1;
   localparam int KEY_IDX_W = (MAX_KEYS > 1) ? $clog2(MAX_KEYS) : 1;
   localparam int COUNT_W   = $clog2(MAX_KEYS + 1);
   localparam int ROM_IDX_W = $clog2(ROM_SIZE);

   localparam int CSR_IDX_W = 3;
   localparam logic [CSR_IDX_W-1:0] CSR_SLEEP_DELAY     = 3'd0;
   localparam logic [CSR_IDX_W-1:0] CSR_GIVE_UP         = 3'd1;
   localparam logic [CSR_IDX_W-1:0] CSR_BATTERY_INT     = 3'd2;
   localparam logic [CSR_IDX_W-1:0] CSR_SCAN_INT        = 3'd3;
   localparam logic [CSR_IDX_W-1:0] CSR_BLINK_CONNECTED = 3'd4;
   localparam logic [CSR_IDX_W-1:0] CSR_BLINK_CONNECTING = 3'd5;
   localparam logic [CSR_IDX_W-1:0] CSR_BLINK_ON        = 3'd6;

   localparam logic [7:0] KEYMAP_ROM [ROM_SIZE] = '{
      8'h28, 8'h29, 8'h4F, 8'h50, 8'h52, 8'h51, 8'h3C, 8'h3D, 8'h1A, 8'h06, 8'h44, 8'h3B, 8'h0B,
      8'h28, 8'h29, 8'h4F, 8'h50, 8'h52, 8'h51, 8'h1E, 8'h20, 8'h1A, 8'h06, 8'h44, 8'h45, 8'h0B
   };

   typedef logic [MAX_KEYS-1:0][7:0] keys_type;

   typedef struct packed {
      logic ge;   // (a - b) mod 2^32 >= thr
      logic eq;   // (a - b) mod 2^32 == thr
   } cmp_res_type;

   typedef struct packed {
      logic               busy;
      logic [COUNT_W-1:0] count;
      keys_type           keys;
   } scan_stat_type;

   // entries past the table read as keycode 0
   function automatic logic [7:0] keymap_code(input logic [KMI_W-1:0] kmi,
                                              input logic [BTN_IDX_W-1:0] btn);
      logic [15:0] idx;
      logic [7:0]  code;
      idx  = 16'(kmi) * 16'(NUM_BUTTONS) + 16'(btn);
      code = 8'h00;
      if (idx < 16'(ROM_SIZE)) begin
         code = KEYMAP_ROM[idx[ROM_IDX_W-1:0]];
      end
      return code;
   endfunction

endpackage

### sv/khpc_cmp.sv
`timescale 1ns / 1ps
// Shared elapsed-time unit: one 32-bit wrapping subtract and compare.
// Depends on khpc_pkg.
module khpc_cmp (
   input  logic [31:0]          a,
   input  logic [31:0]          b,
   input  logic [31:0]          thr,
   output khpc_pkg::cmp_res_type res
);
   import khpc_pkg::*;

   logic [31:0] diff;

   assign diff   = a - b;
   assign res.ge = (diff >= thr);
   assign res.eq = (diff == thr);

endmodule

### sv/khpc_batt.sv
`timescale 1ns / 1ps
// Battery percent pipeline: millivolts, then piecewise scale by reciprocal multiply.
// Two register stages; depends on nothing outside this file.
module khpc_batt (
   input  logic        clock,
   input  logic [11:0] raw,
   output logic [6:0]  pct
);
   localparam logic [12:0] MV_EMPTY = 13'd3300;
   localparam logic [12:0] MV_KNEE  = 13'd3600;
   // x/30 for x < 300, and 3x/20 for x < 2400, both as (x*c) >> 16
   localparam logic [13:0] RECIP_LOW  = 14'd2185;
   localparam logic [13:0] RECIP_HIGH = 14'd9831;

   logic [20:0] mv_prod;
   logic [12:0] mv_in, mv_ff;
   logic [12:0] opnd;
   logic [13:0] coef;
   logic [26:0] prod_in, prod_ff;
   logic        empty_in, empty_ff;
   logic        low_in, low_ff;
   logic [10:0] quot;

   assign mv_prod = 21'(raw) * 21'd375;
   assign mv_in   = mv_prod[20:8];

   assign empty_in = (mv_ff < MV_EMPTY);
   assign low_in   = (mv_ff < MV_KNEE);
   assign opnd     = low_in ? (mv_ff - MV_EMPTY) : (mv_ff - MV_KNEE);
   assign coef     = low_in ? RECIP_LOW : RECIP_HIGH;
   assign prod_in  = 27'(opnd) * 27'(coef);

   always_ff @(posedge clock) begin
      mv_ff    <= mv_in;
      prod_ff  <= prod_in;
      empty_ff <= empty_in;
      low_ff   <= low_in;
   end

   assign quot = prod_ff[26:16];

   always_comb begin
      if (empty_ff) begin
         pct = 7'd0;
      end else if (low_ff) begin
         pct = quot[6:0];
      end else if (quot >= 11'd90) begin
         pct = 7'd100;
      end else begin
         pct = 7'(quot + 11'd10);
      end
   end

endmodule

### sv/khpc_scan.sv
`timescale 1ns / 1ps
// Button scanner: walks the buttons one per cycle and collects keycodes.
// Depends on khpc_pkg for sizes and the keymap table.
module khpc_scan (
   input  logic                           clock,
   input  logic                           reset,
   input  logic                           start,
   input  logic [khpc_pkg::NUM_BUTTONS-1:0] buttons,
   input  logic [khpc_pkg::KMI_W-1:0]     kmi,
   output khpc_pkg::scan_stat_type        stat
);
   import khpc_pkg::*;

   logic                 busy_ff, busy_in;
   logic [BTN_IDX_W-1:0] idx_ff, idx_in;
   logic [COUNT_W-1:0]   count_ff, count_in;
   keys_type             keys_ff, keys_in;

   always_comb begin
      busy_in  = busy_ff;
      idx_in   = idx_ff;
      count_in = count_ff;
      keys_in  = keys_ff;
      if (start) begin
         busy_in  = 1'b1;
         idx_in   = '0;
         count_in = '0;
         keys_in  = '0;
      end else if (busy_ff) begin
         if (buttons[idx_ff] && (count_ff < COUNT_W'(MAX_KEYS))) begin
            keys_in[count_ff[KEY_IDX_W-1:0]] = keymap_code(kmi, idx_ff);
            count_in = count_ff + 1'b1;
         end
         if (idx_ff == BTN_IDX_W'(NUM_BUTTONS - 1)) begin
            busy_in = 1'b0;
         end else begin
            idx_in = idx_ff + 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
      end else begin
         busy_ff <= busy_in;
      end
   end

   always_ff @(posedge clock) begin
      idx_ff   <= idx_in;
      count_ff <= count_in;
      keys_ff  <= keys_in;
   end

   assign stat.busy  = busy_ff;
   assign stat.count = count_ff;
   assign stat.keys  = keys_ff;

endmodule

### sv/keypad_hid_power_controller_unit.sv
`timescale 1ns / 1ps
// Keypad HID power controller top level: poll sequencer, state and registers.
// Depends on khpc_pkg, khpc_cmp, khpc_batt and khpc_scan.
//
//  channel | direction | handshake            | payload
//  req     | in        | req_valid/req_stall  | now_ms, connected, buttons, mode_button,
//          |           |                      | battery_raw
//  rsp     | out       | rsp_valid/rsp_stall  | sleep_request, battery, key report, led_on
//  csr     | in        | csr_valid/csr_ready  | csr_index, csr_wdata
//
// One poll at a time. Every elapsed-time test runs through the one shared compare
// unit, one per cycle. A poll steps through link, sleep, give-up, scan-interval,
// battery, scan, LED-on and LED-period to done; a key scan, when it runs, walks
// the buttons one per cycle. A sleep request skips the rest, and once asleep a
// poll goes straight to done. Reset is synchronous and restores the register defaults.
// rsp_stall holds the result register; the next poll may be accepted meanwhile.
module keypad_hid_power_controller_unit (
   input  logic                             clock,
   input  logic                             reset,
   input  logic                             req_valid,
   output logic                             req_stall,
   input  logic [31:0]                      req_now_ms,
   input  logic                             req_connected,
   input  logic [khpc_pkg::NUM_BUTTONS-1:0] req_buttons,
   input  logic                             req_mode_button,
   input  logic [11:0]                      req_battery_raw,
   output logic                             rsp_valid,
   input  logic                             rsp_stall,
   output logic                             rsp_sleep_request,
   output logic                             rsp_battery_valid,
   output logic [6:0]                       rsp_battery_percent,
   output logic                             rsp_report_valid,
   output logic                             rsp_release_all,
   output logic [7:0]                       rsp_key_a,
   output logic [7:0]                       rsp_key_b,
   output logic [7:0]                       rsp_key_c,
   output logic [7:0]                       rsp_key_d,
   output logic [7:0]                       rsp_key_e,
   output logic [7:0]                       rsp_key_f,
   output logic                             rsp_led_on,
   input  logic                             csr_valid,
   output logic                             csr_ready,
   input  logic [khpc_pkg::CSR_IDX_W-1:0]   csr_index,
   input  logic [31:0]                      csr_wdata
);
   import khpc_pkg::*;

   typedef enum logic [3:0] {
      ST_IDLE, ST_LINK, ST_SLEEP, ST_GIVEUP, ST_SCANCHK,
      ST_BATT, ST_SCAN, ST_LEDON, ST_LEDPER, ST_DONE
   } state_type;

   typedef struct packed {
      logic       sleep_request;
      logic       battery_valid;
      logic [6:0] battery_percent;
      logic       report_valid;
      logic       release_all;
      keys_type   keys;
      logic       led_on;
   } result_type;

   state_type state_ff, state_in;

   // latched poll
   logic [31:0]            now_ff, now_in;
   logic                   conn_ff, conn_in;
   logic [NUM_BUTTONS-1:0] buttons_ff, buttons_in;
   logic                   mode_ff, mode_in;
   logic [11:0]            raw_ff, raw_in;

   // configuration
   logic [31:0] sleep_delay_ff, sleep_delay_in;
   logic [31:0] give_up_ff, give_up_in;
   logic [31:0] batt_int_ff, batt_int_in;
   logic [15:0] scan_int_ff, scan_int_in;
   logic [31:0] blink_conn_ff, blink_conn_in;
   logic [31:0] blink_wait_ff, blink_wait_in;
   logic [15:0] blink_on_ff, blink_on_in;

   // controller state
   logic               link_was_up_ff, link_was_up_in;
   logic [31:0]        last_press_ff, last_press_in;
   logic [31:0]        last_batt_ff, last_batt_in;
   logic [31:0]        last_blink_ff, last_blink_in;
   logic [31:0]        last_link_ff, last_link_in;
   logic [COUNT_W-1:0] last_count_ff, last_count_in;
   logic [KMI_W-1:0]   kmi_ff, kmi_in;
   logic               batt_reported_ff, batt_reported_in;
   logic               asleep_ff, asleep_in;

   logic ge_sleep_ff, ge_sleep_in;
   logic scan_ok_ff, scan_ok_in;

   result_type res_ff, res_in;
   result_type out_ff, out_in;
   logic       rsp_valid_ff, rsp_valid_in;

   logic [31:0]   cmp_b, cmp_thr;
   cmp_res_type   cmp;
   logic [6:0]    batt_pct;
   logic          scan_start;
   scan_stat_type scan;

   khpc_cmp u_cmp (
      .a   (now_ff),
      .b   (cmp_b),
      .thr (cmp_thr),
      .res (cmp)
   );

   khpc_batt u_batt (
      .clock (clock),
      .raw   (raw_ff),
      .pct   (batt_pct)
   );

   khpc_scan u_scan (
      .clock   (clock),
      .reset   (reset),
      .start   (scan_start),
      .buttons (buttons_ff),
      .kmi     (kmi_ff),
      .stat    (scan)
   );

   assign req_stall  = (state_ff != ST_IDLE);
   assign csr_ready  = 1'b1;
   assign scan_start = (state_ff == ST_BATT) && scan_ok_ff && !mode_ff;

   // operand select for the shared compare unit
   always_comb begin
      case (state_ff)
         ST_SLEEP: begin
            cmp_b   = last_press_ff;
            cmp_thr = sleep_delay_ff;
         end
         ST_GIVEUP: begin
            cmp_b   = last_link_ff;
            cmp_thr = give_up_ff;
         end
         ST_SCANCHK: begin
            cmp_b   = last_press_ff;
            cmp_thr = 32'(scan_int_ff);
         end
         ST_BATT: begin
            cmp_b   = last_batt_ff;
            cmp_thr = batt_int_ff;
         end
         ST_LEDON: begin
            cmp_b   = last_blink_ff;
            cmp_thr = 32'(blink_on_ff);
         end
         ST_LEDPER: begin
            cmp_b   = last_blink_ff;
            cmp_thr = conn_ff ? blink_conn_ff : blink_wait_ff;
         end
         default: begin
            cmp_b   = last_press_ff;
            cmp_thr = sleep_delay_ff;
         end
      endcase
   end

   always_comb begin
      state_in         = state_ff;
      now_in           = now_ff;
      conn_in          = conn_ff;
      buttons_in       = buttons_ff;
      mode_in          = mode_ff;
      raw_in           = raw_ff;
      sleep_delay_in   = sleep_delay_ff;
      give_up_in       = give_up_ff;
      batt_int_in      = batt_int_ff;
      scan_int_in      = scan_int_ff;
      blink_conn_in    = blink_conn_ff;
      blink_wait_in    = blink_wait_ff;
      blink_on_in      = blink_on_ff;
      link_was_up_in   = link_was_up_ff;
      last_press_in    = last_press_ff;
      last_batt_in     = last_batt_ff;
      last_blink_in    = last_blink_ff;
      last_link_in     = last_link_ff;
      last_count_in    = last_count_ff;
      kmi_in           = kmi_ff;
      batt_reported_in = batt_reported_ff;
      asleep_in        = asleep_ff;
      ge_sleep_in      = ge_sleep_ff;
      scan_ok_in       = scan_ok_ff;
      res_in           = res_ff;
      out_in           = out_ff;
      rsp_valid_in     = rsp_valid_ff;

      if (csr_valid && csr_ready) begin
         case (csr_index)
            CSR_SLEEP_DELAY:      sleep_delay_in = csr_wdata;
            CSR_GIVE_UP:          give_up_in     = csr_wdata;
            CSR_BATTERY_INT:      batt_int_in    = csr_wdata;
            CSR_SCAN_INT:         scan_int_in    = csr_wdata[15:0];
            CSR_BLINK_CONNECTED:  blink_conn_in  = csr_wdata;
            CSR_BLINK_CONNECTING: blink_wait_in  = csr_wdata;
            CSR_BLINK_ON:         blink_on_in    = csr_wdata[15:0];
            default: ;
         endcase
      end

      if (rsp_valid_ff && !rsp_stall) begin
         rsp_valid_in = 1'b0;
      end

      case (state_ff)
         ST_IDLE: begin
            if (req_valid) begin
               now_in     = req_now_ms;
               conn_in    = req_connected;
               buttons_in = req_buttons;
               mode_in    = req_mode_button;
               raw_in     = req_battery_raw;
               res_in     = '0;
               if (asleep_ff) begin
                  res_in.sleep_request = 1'b1;
                  state_in = ST_DONE;
               end else begin
                  state_in = ST_LINK;
               end
            end
         end
         ST_LINK: begin
            if (conn_ff && !link_was_up_ff) begin
               last_press_in = now_ff;
            end else if (!conn_ff && link_was_up_ff) begin
               batt_reported_in = 1'b0;
            end
            link_was_up_in = conn_ff;
            if (conn_ff) begin
               last_link_in = now_ff;
            end
            state_in = ST_SLEEP;
         end
         ST_SLEEP: begin
            ge_sleep_in = cmp.ge;
            state_in    = ST_GIVEUP;
         end
         ST_GIVEUP: begin
            if ((conn_ff && ge_sleep_ff) || (!conn_ff && cmp.ge)) begin
               asleep_in            = 1'b1;
               res_in.sleep_request = 1'b1;
               state_in             = ST_DONE;
            end else begin
               state_in = ST_SCANCHK;
            end
         end
         ST_SCANCHK: begin
            scan_ok_in = conn_ff && cmp.ge;
            state_in   = ST_BATT;
         end
         ST_BATT: begin
            if (conn_ff && (!batt_reported_ff || cmp.ge)) begin
               res_in.battery_valid   = 1'b1;
               res_in.battery_percent = batt_pct;
               last_batt_in           = now_ff;
               batt_reported_in       = 1'b1;
            end
            state_in = ST_SCAN;
         end
         ST_SCAN: begin
            if (!(scan_ok_ff && !mode_ff && scan.busy)) begin
               if (scan_ok_ff) begin
                  if (mode_ff) begin
                     kmi_in = (kmi_ff == KMI_W'(NUM_KEYMAPS - 1)) ? '0 : kmi_ff + 1'b1;
                     last_press_in = now_ff;
                  end else begin
                     if (scan.count != last_count_ff) begin
                        if (scan.count != '0) begin
                           res_in.report_valid = 1'b1;
                           res_in.keys         = scan.keys;
                        end else begin
                           res_in.release_all = 1'b1;
                        end
                        last_count_in = scan.count;
                     end
                     if (scan.count != '0) begin
                        last_press_in = now_ff;
                     end
                  end
               end
               state_in = ST_LEDON;
            end
         end
         ST_LEDON: begin
            res_in.led_on = !cmp.ge || cmp.eq;
            state_in      = ST_LEDPER;
         end
         ST_LEDPER: begin
            if (cmp.ge) begin
               last_blink_in = now_ff;
            end
            state_in = ST_DONE;
         end
         ST_DONE: begin
            if (!rsp_valid_ff || !rsp_stall) begin
               out_in       = res_ff;
               rsp_valid_in = 1'b1;
               state_in     = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff         <= ST_IDLE;
         sleep_delay_ff   <= 32'd30000;
         give_up_ff       <= 32'd30000;
         batt_int_ff      <= 32'd60000;
         scan_int_ff      <= 16'd100;
         blink_conn_ff    <= 32'd10000;
         blink_wait_ff    <= 32'd1000;
         blink_on_ff      <= 16'd10;
         link_was_up_ff   <= 1'b0;
         last_press_ff    <= '0;
         last_batt_ff     <= '0;
         last_blink_ff    <= '0;
         last_link_ff     <= '0;
         last_count_ff    <= '0;
         kmi_ff           <= '0;
         batt_reported_ff <= 1'b0;
         asleep_ff        <= 1'b0;
         ge_sleep_ff      <= 1'b0;
         scan_ok_ff       <= 1'b0;
         rsp_valid_ff     <= 1'b0;
      end else begin
         state_ff         <= state_in;
         sleep_delay_ff   <= sleep_delay_in;
         give_up_ff       <= give_up_in;
         batt_int_ff      <= batt_int_in;
         scan_int_ff      <= scan_int_in;
         blink_conn_ff    <= blink_conn_in;
         blink_wait_ff    <= blink_wait_in;
         blink_on_ff      <= blink_on_in;
         link_was_up_ff   <= link_was_up_in;
         last_press_ff    <= last_press_in;
         last_batt_ff     <= last_batt_in;
         last_blink_ff    <= last_blink_in;
         last_link_ff     <= last_link_in;
         last_count_ff    <= last_count_in;
         kmi_ff           <= kmi_in;
         batt_reported_ff <= batt_reported_in;
         asleep_ff        <= asleep_in;
         ge_sleep_ff      <= ge_sleep_in;
         scan_ok_ff       <= scan_ok_in;
         rsp_valid_ff     <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      now_ff     <= now_in;
      conn_ff    <= conn_in;
      buttons_ff <= buttons_in;
      mode_ff    <= mode_in;
      raw_ff     <= raw_in;
      res_ff     <= res_in;
      out_ff     <= out_in;
   end

   assign rsp_valid           = rsp_valid_ff;
   assign rsp_sleep_request   = out_ff.sleep_request;
   assign rsp_battery_valid   = out_ff.battery_valid;
   assign rsp_battery_percent = out_ff.battery_percent;
   assign rsp_report_valid    = out_ff.report_valid;
   assign rsp_release_all     = out_ff.release_all;
   assign rsp_key_a           = out_ff.keys[0];
   assign rsp_key_b           = out_ff.keys[1];
   assign rsp_key_c           = out_ff.keys[2];
   assign rsp_key_d           = out_ff.keys[3];
   assign rsp_key_e           = out_ff.keys[4];
   assign rsp_key_f           = out_ff.keys[5];
   assign rsp_led_on          = out_ff.led_on;

   // once asleep, only reset wakes the block
   a_asleep_sticky: assert property (@(posedge clock) disable iff (reset)
      asleep_ff |=> asleep_ff)
      else $error("asleep flag dropped without reset");

   a_sleep_alone: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && rsp_sleep_request) |->
         (!rsp_battery_valid && !rsp_report_valid && !rsp_release_all && !rsp_led_on))
      else $error("sleep result carries other fields");

   a_report_xor_release: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> !(rsp_report_valid && rsp_release_all))
      else $error("key report and release in one transaction");

   a_pct_range: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && rsp_battery_valid) |-> (rsp_battery_percent <= 7'd100))
      else $error("battery percent above 100");

   a_scan_in_window: assert property (@(posedge clock) disable iff (reset)
      scan.busy |-> (state_ff == ST_SCAN))
      else $error("scanner running outside the scan step");

endmodule
